/* rtl/gdff_pkg.sv */
// ----------------------------------------------------------------------------
// gdff_pkg
// Shared types, codes and defaults of the grid flow-field builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdff_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int LIST_DEPTH_DEF = 4096;
  localparam int COST_BITS_DEF  = 8;

  localparam int CFG_W_RESET = 64;
  localparam int CFG_H_RESET = 64;

  localparam int DIST_BITS = 21;
  localparam logic [DIST_BITS-1:0] DIST_INF = '1;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNREACH   = 3'd1,
    ST_QUERY_OOB = 3'd2,
    ST_TGT_OOB   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // Step codes kept per cell
  typedef enum logic [2:0] {
    STEP_NONE = 3'd0,
    STEP_NX   = 3'd1,
    STEP_PX   = 3'd2,
    STEP_NY   = 3'd3,
    STEP_PY   = 3'd4
  } step_t;

  localparam int CFG_IDX_WIDTH  = 1'b0;
  localparam int CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_DECODE,
    S_CLR,
    S_TGT_RD,
    S_TGT_CHK,
    S_SCAN,
    S_POP,
    S_POP_WAIT,
    S_NB,
    S_NB_CHK,
    S_Q_CHK,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

/* rtl/gdff_ram.sv */
// ----------------------------------------------------------------------------
// gdff_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/grid_dijkstra_flow_field.sv */
// ----------------------------------------------------------------------------
// grid_dijkstra_flow_field
// 4-neighbor Dijkstra flow-field builder over a loaded grid of cells.
// ----------------------------------------------------------------------------
// A load beat writes one cell (blocked flag, cost) and gives no result. A
// query beat returns the step toward the last build target, or unreachable
// / out of bounds. A build beat with its target in the grid first sweeps
// the distance/step memory, one cell a cycle, then runs Dijkstra: each pop
// scans the pending list through its single read port, then reads the
// popped cell and checks each neighbor, all around one shared saturating
// add and compare. After reset the same sweep runs once with s_tready low;
// configuration writes are taken at any time. The input is accepted again
// once the block returns to idle, while a result may still wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_dijkstra_flow_field #(
  parameter int MAX_WIDTH  = gdff_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gdff_pkg::MAX_HEIGHT_DEF,
  parameter int LIST_DEPTH = gdff_pkg::LIST_DEPTH_DEF,
  parameter int COST_BITS  = gdff_pkg::COST_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] pos_x, [15:8] pos_y, [16] cell_blocked, [24:17] cell_cost
  input  wire logic [31:0] s_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] step_x, [3:2] step_y
  output logic [7:0]       m_tdata,
  // [2:0] status
  output logic [2:0]       m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import gdff_pkg::*;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int CAW    = $clog2(CELLS);
  localparam int LAW    = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int MAP_W  = 1 + COST_BITS;
  localparam int FLD_W  = DIST_BITS + 3;
  localparam int LST_W  = XW + YW + DIST_BITS;
  localparam int BW_RST = (CFG_W_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_W_RESET;
  localparam int BH_RST = (CFG_H_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_H_RESET;

  // Configuration
  logic [6:0] map_width, map_height;
  logic [7:0] eff_w, eff_h, built_w, built_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= 7'(CFG_W_RESET);
      map_height <= 7'(CFG_H_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == 1'(CFG_IDX_WIDTH)) begin
        map_width <= cfg_data;
      end else begin
        map_height <= cfg_data;
      end
    end
  end

  assign eff_w = ({1'b0, map_width} > 8'(MAX_WIDTH))  ? 8'(MAX_WIDTH)  : {1'b0, map_width};
  assign eff_h = ({1'b0, map_height} > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : {1'b0, map_height};

  function automatic logic [CAW-1:0] cell_addr(input logic [XW-1:0] xx,
                                                input logic [YW-1:0] yy);
    cell_addr = CAW'(CAW'(yy) * CAW'(MAX_WIDTH) + CAW'(xx));
  endfunction

  // Request registers
  state_t                 state, state_next;
  req_t                   rq_type;
  logic [7:0]             rq_x, rq_y;
  logic                   rq_blk;
  logic [7:0]             rq_cost;

  // Build datapath
  logic [CAW-1:0]         clr_idx;
  logic [CNT_W-1:0]       count, scan_idx;
  logic [LAW-1:0]         scan_tag, mi;
  logic                   scan_vld;
  logic [XW-1:0]          cur_x, nb_x;
  logic [YW-1:0]          cur_y, nb_y;
  logic [DIST_BITS-1:0]   min_d, nd;
  logic [1:0]             dir;
  status_t                res_status;
  logic [1:0]             res_sx, res_sy;

  // Memories
  logic                   map_we, fld_we, lst_we;
  logic [CAW-1:0]         map_waddr, map_raddr, fld_waddr, fld_raddr;
  logic [LAW-1:0]         lst_waddr, lst_raddr;
  logic [MAP_W-1:0]       map_wdata, map_rdata;
  logic [FLD_W-1:0]       fld_wdata, fld_rdata;
  logic [LST_W-1:0]       lst_wdata, lst_rdata;

  gdff_ram #(.WIDTH(MAP_W), .DEPTH(CELLS)) u_map (
    .clk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata));

  gdff_ram #(.WIDTH(FLD_W), .DEPTH(CELLS)) u_fld (
    .clk, .we(fld_we), .waddr(fld_waddr), .wdata(fld_wdata),
    .raddr(fld_raddr), .rdata(fld_rdata));

  gdff_ram #(.WIDTH(LST_W), .DEPTH(LIST_DEPTH)) u_lst (
    .clk, .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
    .raddr(lst_raddr), .rdata(lst_rdata));

  // Field entry: {dist, step code}; list entry: {dist, y, x}
  logic [DIST_BITS-1:0]   fld_d, lst_d;
  logic [2:0]             fld_code;
  logic [XW-1:0]          lst_x;
  logic [YW-1:0]          lst_y;
  logic                   map_blk;
  logic [COST_BITS-1:0]   map_cost;

  assign fld_d    = fld_rdata[FLD_W-1:3];
  assign fld_code = fld_rdata[2:0];
  assign lst_x    = lst_rdata[XW-1:0];
  assign lst_y    = lst_rdata[XW +: YW];
  assign lst_d    = lst_rdata[LST_W-1 -: DIST_BITS];
  assign map_blk  = map_rdata[COST_BITS];
  assign map_cost = map_rdata[COST_BITS-1:0];

  // Request bounds
  logic rq_in_store, rq_in_grid, rq_in_built;
  logic [XW-1:0] rq_cx;
  logic [YW-1:0] rq_cy;
  logic [COST_BITS+7:0] cost_ext;

  assign rq_cx       = rq_x[XW-1:0];
  assign rq_cy       = rq_y[YW-1:0];
  assign cost_ext    = {{COST_BITS{1'b0}}, rq_cost};
  assign rq_in_store = !rq_x[7] && !rq_y[7] && (rq_x < 8'(MAX_WIDTH)) &&
                       (rq_y < 8'(MAX_HEIGHT));
  assign rq_in_grid  = !rq_x[7] && !rq_y[7] && (rq_x < eff_w) && (rq_y < eff_h);
  assign rq_in_built = !rq_x[7] && !rq_y[7] && (rq_x < built_w) && (rq_y < built_h);

  // Neighbor of the popped cell in direction dir: +x, -x, +y, -y
  logic [XW:0] px1;
  logic [YW:0] py1;
  logic        nb_ok;
  logic [XW-1:0] nbc_x;
  logic [YW-1:0] nbc_y;

  assign px1 = {1'b0, cur_x} + 1'b1;
  assign py1 = {1'b0, cur_y} + 1'b1;

  always_comb begin
    nbc_x = cur_x;
    nbc_y = cur_y;
    nb_ok = 1'b0;
    case (dir)
      2'd0: begin
        nbc_x = px1[XW-1:0];
        nb_ok = 8'(px1) < built_w;
      end
      2'd1: begin
        nbc_x = cur_x - 1'b1;
        nb_ok = cur_x != '0;
      end
      2'd2: begin
        nbc_y = py1[YW-1:0];
        nb_ok = 8'(py1) < built_h;
      end
      default: begin
        nbc_y = cur_y - 1'b1;
        nb_ok = cur_y != '0;
      end
    endcase
  end

  // Shared unit: saturating add of base distance and cost
  logic [DIST_BITS:0]   sum;
  logic [DIST_BITS-1:0] sum_sat;

  assign sum     = {1'b0, fld_d} + (DIST_BITS+1)'(map_cost);
  assign sum_sat = (sum >= {1'b0, DIST_INF}) ? DIST_INF - 1'b1 : sum[DIST_BITS-1:0];

  logic relax, list_full, scan_done, out_free;
  assign relax     = !map_blk && (nd < fld_d);
  assign list_full = count >= CNT_W'(LIST_DEPTH);
  assign scan_done = !scan_vld && (scan_idx == count);
  assign out_free  = !m_tvalid || m_tready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_BOOT:     if (clr_idx == CAW'(CELLS - 1)) state_next = S_IDLE;
      S_IDLE:     if (s_tvalid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (rq_type)
          REQ_BUILD: state_next = rq_in_grid ? S_CLR : S_RESP;
          REQ_QUERY: state_next = rq_in_built ? S_Q_CHK : S_RESP;
          default:   state_next = S_IDLE;
        endcase
      end
      S_CLR:      if (clr_idx == CAW'(CELLS - 1)) state_next = S_TGT_RD;
      S_TGT_RD:   state_next = S_TGT_CHK;
      S_TGT_CHK:  state_next = S_SCAN;
      S_SCAN: begin
        if (count == '0) state_next = S_RESP;
        else if (scan_done) state_next = S_POP;
      end
      S_POP:      state_next = S_POP_WAIT;
      S_POP_WAIT: state_next = S_NB;
      S_NB: begin
        if (nb_ok) state_next = S_NB_CHK;
        else if (dir == 2'd3) state_next = S_SCAN;
      end
      S_NB_CHK: begin
        if (relax && list_full) state_next = S_RESP;
        else if (dir == 2'd3) state_next = S_SCAN;
        else state_next = S_NB;
      end
      S_Q_CHK:    state_next = S_RESP;
      S_RESP:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    s_tready  = state == S_IDLE;
    map_we    = 1'b0;
    map_waddr = cell_addr(rq_cx, rq_cy);
    map_wdata = {rq_blk, cost_ext[COST_BITS-1:0]};
    map_raddr = cell_addr(rq_cx, rq_cy);
    fld_we    = 1'b0;
    fld_waddr = clr_idx;
    fld_wdata = {DIST_INF, STEP_NONE};
    fld_raddr = cell_addr(rq_cx, rq_cy);
    lst_we    = 1'b0;
    lst_waddr = '0;
    lst_wdata = {{DIST_BITS{1'b0}}, rq_cy, rq_cx};
    lst_raddr = scan_idx[LAW-1:0];
    unique case (state)
      S_BOOT, S_CLR: fld_we = 1'b1;
      S_DECODE: map_we = (rq_type == REQ_LOAD) && rq_in_store;
      S_TGT_CHK: begin
        fld_waddr = cell_addr(rq_cx, rq_cy);
        fld_wdata = {{DIST_BITS{1'b0}}, STEP_NONE};
        fld_we    = !map_blk;
        lst_we    = !map_blk;
      end
      S_POP: begin
        lst_raddr = LAW'(count - 1'b1);
        fld_raddr = cell_addr(cur_x, cur_y);
        map_raddr = cell_addr(cur_x, cur_y);
      end
      S_POP_WAIT: begin
        lst_we    = 1'b1;
        lst_waddr = mi;
        lst_wdata = lst_rdata;
      end
      S_NB: begin
        fld_raddr = cell_addr(nbc_x, nbc_y);
        map_raddr = cell_addr(nbc_x, nbc_y);
      end
      S_NB_CHK: begin
        fld_waddr = cell_addr(nb_x, nb_y);
        fld_wdata = {nd, 3'(dir) + 3'd1};
        fld_we    = relax;
        lst_waddr = count[LAW-1:0];
        lst_wdata = {nd, nb_y, nb_x};
        lst_we    = relax && !list_full;
      end
      default: ;
    endcase
  end

  // Datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_BOOT;
      clr_idx  <= '0;
      count    <= '0;
      scan_vld <= 1'b0;
      scan_idx <= '0;
      built_w  <= 8'(BW_RST);
      built_h  <= 8'(BH_RST);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // Drop the result once taken; the response state loads the next one
      if (m_tready && state != S_RESP) m_tvalid <= 1'b0;
      unique case (state)
        S_BOOT, S_CLR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: begin
          rq_type <= req_t'(s_tuser);
          rq_x    <= s_tdata[7:0];
          rq_y    <= s_tdata[15:8];
          rq_blk  <= s_tdata[16];
          rq_cost <= s_tdata[24:17];
        end
        S_DECODE: begin
          res_status <= (rq_type == REQ_BUILD) ? ST_TGT_OOB : ST_QUERY_OOB;
          res_sx     <= '0;
          res_sy     <= '0;
          clr_idx    <= '0;
          if (rq_type == REQ_BUILD && rq_in_grid) begin
            built_w <= eff_w;
            built_h <= eff_h;
          end
        end
        S_TGT_CHK: begin
          count      <= map_blk ? CNT_W'(0) : CNT_W'(1);
          scan_idx   <= '0;
          scan_vld   <= 1'b0;
          res_status <= ST_OK;
        end
        S_SCAN: begin
          if (scan_vld && (scan_tag == '0 || lst_d < min_d)) begin
            mi    <= scan_tag;
            cur_x <= lst_x;
            cur_y <= lst_y;
            min_d <= lst_d;
          end
          if (scan_idx != count) begin
            scan_tag <= scan_idx[LAW-1:0];
            scan_idx <= scan_idx + 1'b1;
            scan_vld <= 1'b1;
          end else begin
            scan_vld <= 1'b0;
          end
        end
        S_POP: count <= count - 1'b1;
        S_POP_WAIT: begin
          nd  <= sum_sat;
          dir <= '0;
        end
        S_NB: begin
          nb_x <= nbc_x;
          nb_y <= nbc_y;
          if (!nb_ok) begin
            dir <= dir + 1'b1;
            if (dir == 2'd3) begin
              scan_idx <= '0;
              scan_vld <= 1'b0;
            end
          end
        end
        S_NB_CHK: begin
          dir <= dir + 1'b1;
          if (relax && list_full) begin
            res_status <= ST_OVERFLOW;
          end else if (relax) begin
            count <= count + 1'b1;
          end
          scan_idx <= '0;
          scan_vld <= 1'b0;
        end
        S_Q_CHK: begin
          res_status <= (fld_d == DIST_INF) ? ST_UNREACH : ST_OK;
          res_sx     <= '0;
          res_sy     <= '0;
          if (fld_d != DIST_INF) begin
            case (fld_code)
              STEP_NX: res_sx <= 2'b11;
              STEP_PX: res_sx <= 2'b01;
              STEP_NY: res_sy <= 2'b11;
              STEP_PY: res_sy <= 2'b01;
              default: ;
            endcase
          end
        end
        S_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {4'b0000, res_sy, res_sx};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LIST_DEPTH))
    else $error("pending count beyond list depth");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR || state == S_BOOT || state == S_SCAN) |-> !s_tready)
    else $error("input taken while busy");

  a_resp_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_free) |=> m_tvalid)
    else $error("result not presented");

  a_nb_chk_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_NB_CHK) |-> $past(state) == S_NB)
    else $error("neighbor check without neighbor read");
`endif

endmodule

`default_nettype wire

/* bench/grid_dijkstra_flow_field_tb.sv */
// ----------------------------------------------------------------------------
// grid_dijkstra_flow_field_tb
// Self-checking bench for the grid flow-field builder: loads cell regions,
// builds fields over many grid sizes and checks every build and query answer
// against an in-bench Dijkstra predictor, under several idle/stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_dijkstra_flow_field_tb;
  import gdff_pkg::*;

  localparam int GRID_W     = 64;
  localparam int GRID_H     = 64;
  localparam int CELL_COUNT = GRID_W * GRID_H;
  localparam int OPEN_DEPTH = 4096;
  localparam int HANG_LIMIT = 4000000;

  typedef struct packed {
    status_t    st;
    logic [1:0] sx;
    logic [1:0] sy;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [6:0]  cfg_data;

  grid_dijkstra_flow_field dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Predictor state: a mirror of the grid, the field and the open list
  logic                 flow_blocked [CELL_COUNT];
  logic [7:0]           flow_cost    [CELL_COUNT];
  logic [DIST_BITS-1:0] flow_dist    [CELL_COUNT];
  step_t                flow_step    [CELL_COUNT];
  int                   open_x [OPEN_DEPTH];
  int                   open_y [OPEN_DEPTH];
  logic [DIST_BITS-1:0] open_d [OPEN_DEPTH];
  int                   cfg_w, cfg_h, built_w, built_h;

  answer_t answers_due[$];
  int      fail_count;
  int      build_count, query_count, answer_count;
  int      idle_cycles;
  int      idle_pct, stall_pct;

  function automatic int eff_size(int v);
    return (v > GRID_W) ? GRID_W : v;
  endfunction

  // Dijkstra toward (tx,ty); linear scan for the first strict minimum,
  // popped slot refilled with the last entry.
  function automatic status_t plan_build(int tx, int ty);
    int w, h, cnt, mi, cx, cy, nx, ny, ni;
    logic [DIST_BITS-1:0] base;
    logic [31:0] nd;
    w = eff_size(cfg_w);
    h = eff_size(cfg_h);
    if (w <= 0 || h <= 0 || tx < 0 || ty < 0 || tx >= w || ty >= h) return ST_TGT_OOB;
    for (int i = 0; i < CELL_COUNT; i++) begin
      flow_dist[i] = DIST_INF;
      flow_step[i] = STEP_NONE;
    end
    built_w = w;
    built_h = h;
    cnt = 0;
    if (!flow_blocked[ty*GRID_W+tx]) begin
      flow_dist[ty*GRID_W+tx] = '0;
      open_x[0] = tx; open_y[0] = ty; open_d[0] = '0;
      cnt = 1;
    end
    while (cnt > 0) begin
      mi = 0;
      for (int k = 1; k < cnt; k++)
        if (open_d[k] < open_d[mi]) mi = k;
      cx = open_x[mi];
      cy = open_y[mi];
      cnt--;
      open_x[mi] = open_x[cnt]; open_y[mi] = open_y[cnt]; open_d[mi] = open_d[cnt];
      base = flow_dist[cy*GRID_W+cx];
      for (int d = 0; d < 4; d++) begin
        nx = cx + ((d == 0) ? 1 : (d == 1) ? -1 : 0);
        ny = cy + ((d == 2) ? 1 : (d == 3) ? -1 : 0);
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        ni = ny*GRID_W + nx;
        if (flow_blocked[ni]) continue;
        nd = 32'(base) + 32'(flow_cost[cy*GRID_W+cx]);
        if (nd >= 32'(DIST_INF)) nd = 32'(DIST_INF) - 1;
        if (nd < 32'(flow_dist[ni])) begin
          flow_dist[ni] = nd[DIST_BITS-1:0];
          flow_step[ni] = (d == 0) ? STEP_NX : (d == 1) ? STEP_PX : (d == 2) ? STEP_NY : STEP_PY;
          if (cnt >= OPEN_DEPTH) return ST_OVERFLOW;
          open_x[cnt] = nx; open_y[cnt] = ny; open_d[cnt] = nd[DIST_BITS-1:0];
          cnt++;
        end
      end
    end
    return ST_OK;
  endfunction

  // Apply one accepted item to the predictor and queue its answer, if any
  task automatic predict_item(req_t req, int x, int y, logic blk, logic [7:0] cost);
    answer_t a;
    a = '{st: ST_OK, sx: 2'b00, sy: 2'b00};
    case (req)
      REQ_LOAD: begin
        if (x >= 0 && y >= 0 && x < GRID_W && y < GRID_H) begin
          flow_blocked[y*GRID_W+x] = blk;
          flow_cost[y*GRID_W+x]    = cost;
        end
      end
      REQ_BUILD: begin
        a.st = plan_build(x, y);
        answers_due.push_back(a);
        build_count++;
      end
      REQ_QUERY: begin
        if (x < 0 || y < 0 || x >= built_w || y >= built_h) a.st = ST_QUERY_OOB;
        else if (flow_dist[y*GRID_W+x] == DIST_INF) a.st = ST_UNREACH;
        else begin
          case (flow_step[y*GRID_W+x])
            STEP_NX: a.sx = 2'b11;
            STEP_PX: a.sx = 2'b01;
            STEP_NY: a.sy = 2'b11;
            STEP_PY: a.sy = 2'b01;
            default: ;
          endcase
        end
        answers_due.push_back(a);
        query_count++;
      end
      default: ;
    endcase
  endtask

  // Send one beat; hold valid until the handshake edge
  task automatic send_item(req_t req, int x, int y, logic blk = 1'b0, logic [7:0] cost = 8'd0);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {7'd0, cost, blk, 8'(y), 8'(x)};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predict_item(req, x, y, blk, cost);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDX_WIDTH[0]) cfg_w = val;
    else cfg_h = val;
  endtask

  // Drain outstanding answers, let a trailing load settle, then resize
  task automatic set_size(int w, int h);
    @(posedge clk);
    s_tvalid <= 1'b0;
    wait (answers_due.size() == 0);
    repeat (20) @(posedge clk);
    write_reg(CFG_IDX_WIDTH[0], 7'(w));
    write_reg(CFG_IDX_HEIGHT[0], 7'(h));
  endtask

  task automatic load_random_cell(int x, int y);
    logic [7:0] c;
    c = ($urandom_range(9) == 0) ? 8'(($urandom_range(1)) ? 255 : 0) : 8'($urandom);
    send_item(REQ_LOAD, x, y, ($urandom_range(99) < 20), c);
  endtask

  // Load the 16x16 corner plus the whole first row and first column
  task automatic test_load_region();
    for (int y = 0; y < 16; y++)
      for (int x = 0; x < 16; x++) load_random_cell(x, y);
    for (int i = 16; i < GRID_W; i++) begin
      load_random_cell(i, 0);
      load_random_cell(0, i);
    end
  endtask

  // Extremes and special cases
  task automatic test_directed();
    send_item(REQ_QUERY, 3, 3);               // before any build: unreachable
    send_item(REQ_QUERY, -128, 127);          // query out of bounds
    send_item(REQ_LOAD, -128, 5, 1'b1, 8'hFF);  // ignored loads
    send_item(REQ_LOAD, 127, -1, 1'b1, 8'hAA);
    send_item(REQ_LOAD, 5, 127, 1'b0, 8'h55);
    send_item(REQ_NONE, 2, 2, 1'b1, 8'hFF);   // no answer
    set_size(8, 8);
    send_item(REQ_LOAD, 2, 2, 1'b0, 8'hFF);
    send_item(REQ_LOAD, 3, 2, 1'b0, 8'h00);
    send_item(REQ_BUILD, 2, 2);
    send_item(REQ_QUERY, 3, 2);
    send_item(REQ_QUERY, 1, 1);
    send_item(REQ_QUERY, 8, 0);               // just past built width
    send_item(REQ_BUILD, -1, 0);              // target out of bounds
    send_item(REQ_BUILD, 0, 8);
    send_item(REQ_QUERY, 3, 2);               // old field kept
    send_item(REQ_LOAD, 4, 4, 1'b1, 8'h01);
    send_item(REQ_BUILD, 4, 4);               // blocked target
    send_item(REQ_QUERY, 4, 5);
    send_item(REQ_LOAD, 4, 4, 1'b0, 8'h10);
    send_item(REQ_BUILD, 7, 7);
    send_item(REQ_QUERY, 0, 0);
    set_size(0, 5);
    send_item(REQ_BUILD, 0, 0);               // zero width
    send_item(REQ_QUERY, 7, 7);
  endtask

  // Strip, column and clamp extremes
  task automatic test_size_extremes();
    int sizes[6][2] = '{'{64, 1}, '{127, 1}, '{1, 64}, '{1, 127}, '{1, 1}, '{16, 16}};
    for (int s = 0; s < 6; s++) begin
      set_size(sizes[s][0], sizes[s][1]);
      send_item(REQ_BUILD, $urandom_range(eff_size(sizes[s][0]) - 1),
                $urandom_range(eff_size(sizes[s][1]) - 1));
      for (int q = 0; q < 6; q++)
        send_item(REQ_QUERY, $urandom_range(eff_size(sizes[s][0])),
                  $urandom_range(eff_size(sizes[s][1])));
    end
  endtask

  // Random traffic on a random small grid: mostly loads and queries on
  // the current field, occasional rebuilds, a little noise
  task automatic test_random_phase(int idle_s, int stall_r, int items);
    int w, h, r;
    idle_pct  = idle_s;
    stall_pct = stall_r;
    w = $urandom_range(16, 1);
    h = $urandom_range(16, 1);
    set_size(w, h);
    send_item(REQ_BUILD, $urandom_range(w - 1), $urandom_range(h - 1));
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < 40) load_random_cell($urandom_range(15), $urandom_range(15));
      else if (r < 84)
        send_item(REQ_QUERY, $urandom_range(built_w + 1) - 1, $urandom_range(built_h + 1) - 1);
      else if (r < 88)
        send_item(REQ_BUILD, $urandom_range(w + 1) - 1, $urandom_range(h + 1) - 1);
      else if (r < 92) send_item(REQ_QUERY, 8'($urandom), 8'($urandom));
      else if (r < 96)
        send_item(REQ_LOAD, $urandom_range(127, 64), 8'($urandom), $urandom_range(1), 8'($urandom));
      else send_item(REQ_NONE, 8'($urandom), 8'($urandom), $urandom_range(1), 8'($urandom));
    end
  endtask

  // Receiver stalls at random; results checked at the falling edge, where
  // valid/ready/data are stable ahead of the handshake edge
  always @(posedge clk)
    m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

  always @(negedge clk) begin
    answer_t want;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (m_tvalid && m_tready) begin
        answer_count++;
        if (answers_due.size() == 0) begin
          $error("unexpected result: status %0d data %h", m_tuser, m_tdata);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (m_tuser != want.st) begin
            $error("status: expected %0d, got %0d", want.st, m_tuser);
            fail_count++;
          end
          if (m_tdata[1:0] != want.sx) begin
            $error("step_x: expected %0d, got %0d", $signed(want.sx), $signed(m_tdata[1:0]));
            fail_count++;
          end
          if (m_tdata[3:2] != want.sy) begin
            $error("step_y: expected %0d, got %0d", $signed(want.sy), $signed(m_tdata[3:2]));
            fail_count++;
          end
          if (m_tdata[7:4] != 4'd0) begin
            $error("tdata pad: expected 0, got %h", m_tdata[7:4]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = REQ_LOAD;
    cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    m_tready = 1'b1;
    idle_pct = 0; stall_pct = 0;
    fail_count = 0; build_count = 0; query_count = 0; answer_count = 0; idle_cycles = 0;
    cfg_w = CFG_W_RESET; cfg_h = CFG_H_RESET;
    built_w = eff_size(cfg_w); built_h = eff_size(cfg_h);
    for (int i = 0; i < CELL_COUNT; i++) begin
      flow_blocked[i] = 1'b0; flow_cost[i] = '0;
      flow_dist[i] = DIST_INF; flow_step[i] = STEP_NONE;
    end
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_load_region();
    test_directed();
    test_size_extremes();
    test_random_phase(0, 0, 300);
    test_random_phase(71, 0, 300);
    test_random_phase(0, 71, 300);
    test_random_phase(24, 24, 300);

    @(posedge clk);
    s_tvalid <= 1'b0;
    wait (answers_due.size() == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d builds and %0d queries, %0d answers checked,", build_count,
             query_count, answer_count);
    $display("over grid sizes from 0x5 up to 64x1 and 1x64 with mixed idles and stalls.");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/gdff_pkg.sv
rtl/gdff_ram.sv
rtl/grid_dijkstra_flow_field.sv
bench/grid_dijkstra_flow_field_tb.sv
